[hdl/ppe_pkg.sv]
`default_nettype none
package ppe_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int COORD_W      = 32;
    localparam int TOL_W        = 31;
    localparam int STEP_W       = 6;
    localparam int SQRT_STEPS   = 33;
    localparam int DIV_STEPS    = 32;
    localparam int MUL_OPS      = 6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_TOL    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TOL, ST_RDA, ST_RDB, ST_DIFF, ST_MUL, ST_CHK,
        ST_SQRT, ST_DIVI, ST_DIV, ST_UPD, ST_DONE
    } t_state;

    // product selects, TOL first so edge products follow in order
    typedef enum logic [2:0] {
        MOP_TOL, MOP_DXDX, MOP_DYDY, MOP_QXDY, MOP_QYDX, MOP_QXQX, MOP_QYQY
    } t_mop;

    typedef struct packed {
        logic              mem_rd;
        logic [VIDX_W-1:0] rd_addr;
        logic              lat_a;
        logic              diff;
        logic              mul_en;
        t_mop              mul_op;
        logic              cross_en;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              upd;
        logic [VIDX_W-1:0] edge_idx;
        logic              clr_best;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
    } t_stat;

    // packed as the output tdata: distance lowest
    typedef struct packed {
        logic              found;
        logic              near;
        logic [VIDX_W-1:0] edge_idx;
        logic [31:0]       min_dist;
    } t_result;

endpackage
`default_nettype wire

[hdl/ppe_ctrl.sv]
`default_nettype none
module ppe_ctrl
    import ppe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_op,
    input  wire logic             i_out_ready,
    input  wire logic [CNT_W-1:0] i_vcount,
    input  wire t_stat            i_stat,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_cmd                  o_cmd
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [VIDX_W-1:0] r_i, n_i;
    logic r_ovalid, n_ovalid;
    logic [CNT_W-1:0] w_n;
    logic w_last;

    assign w_n    = (i_vcount > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : i_vcount;
    assign w_last = ({1'b0, r_i} + CNT_W'(1)) == w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_i      <= n_i;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_ovalid   = r_ovalid & ~i_out_ready;
        o_cmd      = '0;
        o_cmd.edge_idx = r_i;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_op == OP_QUERY) begin
                    o_cmd.clr_best = 1'b1;
                    n_state = ST_TOL;
                end
            end
            ST_TOL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MOP_TOL;
                n_i = '0;
                n_state = (w_n == '0) ? ST_DONE : ST_RDA;
            end
            ST_RDA: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state = ST_RDB;
            end
            ST_RDB: begin
                o_cmd.lat_a   = 1'b1;
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_addr = w_last ? '0 : r_i + VIDX_W'(1);
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = t_mop'(r_cnt[2:0] + 3'd1);
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(MUL_OPS - 1))
                    n_state = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.cross_en = 1'b1;
                n_cnt = '0;
                if (i_stat.len_zero) begin
                    // degenerate edge: skip it
                    n_i = r_i + VIDX_W'(1);
                    n_state = w_last ? ST_DONE : ST_RDA;
                end else begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(SQRT_STEPS - 1))
                    n_state = ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(DIV_STEPS - 1))
                    n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_i = r_i + VIDX_W'(1);
                n_state = w_last ? ST_DONE : ST_RDA;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

[hdl/ppe_dp.sv]
`default_nettype none
module ppe_dp
    import ppe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_wr_en,
    input  wire logic [VIDX_W-1:0]  i_wr_idx,
    input  wire logic               i_pt_en,
    input  wire logic [COORD_W-1:0] i_x,
    input  wire logic [COORD_W-1:0] i_y,
    input  wire logic [TOL_W-1:0]   i_tol,
    output t_stat                   o_stat,
    output t_result                 o_out
);

    logic [2*COORD_W-1:0] r_mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] r_rd;
    logic [COORD_W-1:0] r_px, r_py, r_ax, r_ay;
    logic [31:0] r_mdx, r_mdy, r_mqx, r_mqy;
    logic r_sdx, r_sdy, r_sqx, r_sqy;
    logic [63:0] r_prod;
    t_mop r_pop;
    logic r_pv;
    logic [61:0] r_tol2;
    logic [64:0] r_len2, r_nq, r_cross;
    logic [63:0] r_m1, r_m2;
    logic [65:0] r_rad;
    logic [34:0] r_srem;
    logic [32:0] r_root, r_drem;
    logic [31:0] r_dlow, r_q, r_best;
    logic r_sat, r_found, r_near;
    logic [VIDX_W-1:0] r_bidx;
    t_result r_out;

    logic [32:0] w_dx, w_dy, w_qx, w_qy;
    logic [31:0] w_ma, w_mb;
    logic [36:0] w_srem, w_trial;
    logic [33:0] w_dt;
    logic [31:0] w_dist;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_idx] <= {i_y, i_x};
        if (i_cmd.mem_rd)
            r_rd <= r_mem[i_cmd.rd_addr];
    end

    always_comb begin
        w_dx = {r_rd[31], r_rd[31:0]} - {r_ax[31], r_ax};
        w_dy = {r_rd[63], r_rd[63:32]} - {r_ay[31], r_ay};
        w_qx = {r_px[31], r_px} - {r_ax[31], r_ax};
        w_qy = {r_py[31], r_py} - {r_ay[31], r_ay};
    end

    always_comb begin
        case (i_cmd.mul_op)
            MOP_TOL:  begin w_ma = {1'b0, i_tol}; w_mb = {1'b0, i_tol}; end
            MOP_DXDX: begin w_ma = r_mdx; w_mb = r_mdx; end
            MOP_DYDY: begin w_ma = r_mdy; w_mb = r_mdy; end
            MOP_QXDY: begin w_ma = r_mqx; w_mb = r_mdy; end
            MOP_QYDX: begin w_ma = r_mqy; w_mb = r_mdx; end
            MOP_QXQX: begin w_ma = r_mqx; w_mb = r_mqx; end
            MOP_QYQY: begin w_ma = r_mqy; w_mb = r_mqy; end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_srem  = {r_srem, r_rad[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_dt    = {r_drem, r_dlow[31]};
    assign w_dist  = r_sat ? '1 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_pt_en) begin
            r_px <= i_x;
            r_py <= i_y;
        end
        if (i_cmd.lat_a) begin
            r_ax <= r_rd[31:0];
            r_ay <= r_rd[63:32];
        end
        if (i_cmd.diff) begin
            r_mdx <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
            r_mdy <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            r_mqx <= w_qx[32] ? 32'(-w_qx) : w_qx[31:0];
            r_mqy <= w_qy[32] ? 32'(-w_qy) : w_qy[31:0];
            r_sdx <= w_dx[32];
            r_sdy <= w_dy[32];
            r_sqx <= w_qx[32];
            r_sqy <= w_qy[32];
        end
        r_prod <= w_ma * w_mb;
        r_pop  <= i_cmd.mul_op;
        // product is registered in r_prod, then lands in its target register while r_pv is set
        if (r_pv) begin
            case (r_pop)
                MOP_TOL:  r_tol2 <= r_prod[61:0];
                MOP_DXDX: r_len2 <= {1'b0, r_prod};
                MOP_DYDY: r_len2 <= r_len2 + {1'b0, r_prod};
                MOP_QXDY: r_m1   <= r_prod;
                MOP_QYDX: r_m2   <= r_prod;
                MOP_QXQX: r_nq   <= {1'b0, r_prod};
                MOP_QYQY: r_nq   <= r_nq + {1'b0, r_prod};
                default:  r_m1   <= r_m1;
            endcase
        end
        if (i_cmd.cross_en) begin
            if ((r_sqx ^ r_sdy) != (r_sqy ^ r_sdx))
                r_cross <= {1'b0, r_m1} + {1'b0, r_m2};
            else
                r_cross <= {1'b0, (r_m1 >= r_m2) ? r_m1 - r_m2 : r_m2 - r_m1};
            r_rad  <= {1'b0, r_len2};
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[63:0], 2'b00};
            if (w_srem >= w_trial) begin
                r_srem <= 35'(w_srem - w_trial);
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_srem <= w_srem[34:0];
                r_root <= {r_root[31:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_sat  <= r_cross[64:32] >= r_root;
            r_drem <= r_cross[64:32];
            r_dlow <= r_cross[31:0];
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_dlow <= {r_dlow[30:0], 1'b0};
            if (w_dt >= {1'b0, r_root}) begin
                r_drem <= 33'(w_dt - {1'b0, r_root});
                r_q    <= {r_q[30:0], 1'b1};
            end else begin
                r_drem <= w_dt[32:0];
                r_q    <= {r_q[30:0], 1'b0};
            end
        end
        if (i_cmd.upd && (!r_found || w_dist < r_best)) begin
            r_best <= w_dist;
            r_bidx <= i_cmd.edge_idx;
            r_near <= r_nq <= {3'b000, r_tol2};
        end
        if (i_cmd.out_load)
            r_out <= r_found ? {1'b1, r_near, r_bidx, r_best} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
            if (i_cmd.clr_best)
                r_found <= 1'b0;
            else if (i_cmd.upd)
                r_found <= 1'b1;
        end
    end

    assign o_stat.len_zero = (r_len2 == '0);
    assign o_out = r_out;

endmodule
`default_nettype wire

[hdl/point_polygon_edge_distance.sv]
// Load: no result. Query: the result becomes valid after the request once every one of
// min(vertex_count, 64) edges is done, zero-length edges being skipped before the root and
// divider; the next request is taken in the cycle after the result is loaded.
// Per edge, the shared 32x32 multiplier forms the edge products, followed by the root and the divider.
// One query at a time; a load or query is taken while a result waits on the output.
// Synchronous active-low reset: vertex_count 4, tolerance 0; vertex store not cleared.
`default_nettype none
module point_polygon_edge_distance
    import ppe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [30:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // vertex_index[5:0], coord_x, coord_y, pad
    input  wire logic         s_axis_tuser,  // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata   // min_distance, edge_index, near_vertex, found
);

    logic [CNT_W-1:0] r_vcount;
    logic [TOL_W-1:0] r_tol;
    logic w_acc;
    t_cmd w_cmd;
    t_stat w_stat;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_W'(4);
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VCOUNT: r_vcount <= i_cfg_data[CNT_W-1:0];
                CFG_TOL:    r_tol    <= i_cfg_data;
                default:    r_tol    <= r_tol;
            endcase
        end
    end

    assign w_acc = s_axis_tvalid & s_axis_tready;

    ppe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_vcount    (r_vcount),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    ppe_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_wr_en  (w_acc & (s_axis_tuser == OP_LOAD)),
        .i_wr_idx (s_axis_tdata[5:0]),
        .i_pt_en  (w_acc & (s_axis_tuser == OP_QUERY)),
        .i_x      (s_axis_tdata[37:6]),
        .i_y      (s_axis_tdata[69:38]),
        .i_tol    (r_tol),
        .o_stat   (w_stat),
        .o_out    (w_out)
    );

    assign m_axis_tdata = w_out;

endmodule
`default_nettype wire

[hdl/ppe_checker.sv]
`default_nettype none
module ppe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[39] |-> m_axis_tdata[38:0] == 39'd0)
        else $error("result without edge carries nonzero fields");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("request taken while a query is in progress");

endmodule

bind point_polygon_edge_distance ppe_checker u_ppe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[dv/tb_point_polygon_edge_distance.sv]
`default_nettype none
module tb_point_polygon_edge_distance
    import ppe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected-result store with its own copy of the polygon and registers.
    class DistanceScoreboard;
        logic signed [31:0] vx [MAX_VERTICES];
        logic signed [31:0] vy [MAX_VERTICES];
        logic [CNT_W-1:0]   vcount;
        logic [TOL_W-1:0]   tol;
        t_result            pending_results [$];
        int                 errors, queries, loads, hits_found, hits_near, hits_sat, checked;

        function new();
            vcount = 7'd4;
            tol    = '0;
        endfunction

        function void set_reg(logic idx, logic [TOL_W-1:0] val);
            if (idx == CFG_VCOUNT)
                vcount = val[CNT_W-1:0];
            else
                tol = val;
        endfunction

        function logic [69:0] int_root(logic [69:0] s);
            logic [69:0] r, c;
            r = '0;
            for (int b = 32; b >= 0; b--) begin
                c = r | (70'd1 << b);
                if (c * c <= s)
                    r = c;
            end
            return r;
        endfunction

        function t_result nearest_edge(logic signed [31:0] px, logic signed [31:0] py);
            t_result res;
            int n, j;
            logic signed [69:0] dx, dy, qx, qy, cr;
            logic [69:0] len2, c, l, t2, d2;
            logic [31:0] edge_dist;
            res = '0;
            n = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
            t2 = tol;
            t2 = t2 * t2;
            for (int i = 0; i < n; i++) begin
                j = (i + 1 >= n) ? 0 : i + 1;
                dx = vx[j];
                dx = dx - vx[i];
                dy = vy[j];
                dy = dy - vy[i];
                qx = px;
                qx = qx - vx[i];
                qy = py;
                qy = qy - vy[i];
                len2 = dx * dx + dy * dy;
                if (len2 == 0)
                    continue;
                cr = qx * dy - qy * dx;
                c = (cr < 0) ? -cr : cr;
                l = int_root(len2);
                if ((l << 32) <= c)
                    edge_dist = '1;
                else
                    edge_dist = 32'(c / l);
                if (!res.found || edge_dist < res.min_dist) begin
                    res.found    = 1'b1;
                    res.min_dist = edge_dist;
                    res.edge_idx = i[VIDX_W-1:0];
                    d2 = qx * qx + qy * qy;
                    res.near     = (d2 <= t2);
                end
            end
            return res;
        endfunction

        function void note_request(logic op, logic [VIDX_W-1:0] idx,
                                   logic [31:0] x, logic [31:0] y);
            t_result r;
            if (op == OP_LOAD) begin
                vx[idx] = x;
                vy[idx] = y;
                loads++;
            end else begin
                r = nearest_edge(x, y);
                pending_results = {pending_results, r};
                queries++;
                if (r.found) hits_found++;
                if (r.near) hits_near++;
                if (r.found && r.min_dist == '1) hits_sat++;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(t_result got);
            t_result w;
            if (pending_results.size() == 0) begin
                report("unexpected result", got.min_dist, 32'd0);
                return;
            end
            w = pending_results.pop_front();
            checked++;
            if (got.min_dist != w.min_dist) report("min_distance", got.min_dist, w.min_dist);
            if (got.edge_idx != w.edge_idx)
                report("edge_index", 32'(got.edge_idx), 32'(w.edge_idx));
            if (got.near != w.near) report("near_vertex", 32'(got.near), 32'(w.near));
            if (got.found != w.found) report("found", 32'(got.found), 32'(w.found));
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int LONG_HOLD      = 2000;

    logic               i_clk, i_rst_n;
    logic               i_cfg_we, i_cfg_index;
    logic [30:0]        i_cfg_data;
    logic               s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [71:0]        s_axis_tdata;
    logic               m_axis_tvalid, m_axis_tready;
    logic [39:0]        m_axis_tdata;

    DistanceScoreboard  sb;
    logic               no_idle, hold_req;
    int                 hold_left, stall_left, idle_cycles;

    point_polygon_edge_distance dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        idle_cycles = 0;
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata));
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [VIDX_W-1:0] idx, logic [31:0] x, logic [31:0] y);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, y, x, idx};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready)
                break;
        end
        sb.note_request(op, idx, x, y);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // block must be idle; leaves the write enable high until the next step lowers it
    task automatic write_reg(logic idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(int style);
        case (style)
            0: return 32'($signed($urandom_range(0, 8191)) - 4096);
            1: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000);
            2: return $urandom();
            default: return 32'(($signed($urandom_range(0, 4)) - 2) << 16);
        endcase
    endfunction

    task automatic run_phase(int vcnt, logic [30:0] tolv, int items, int style);
        int n, sent, r, k, spread;
        logic [31:0] px, py;
        drain();
        write_reg(CFG_VCOUNT, vcnt[30:0]);
        write_reg(CFG_TOL, tolv);
        end_writes();
        n = (vcnt > MAX_VERTICES) ? MAX_VERTICES : vcnt;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 19);
            if (r < 3) begin
                send_item(OP_LOAD, VIDX_W'($urandom()), pick_coord($urandom_range(0, 3)),
                          pick_coord($urandom_range(0, 3)));
                sent++;
            end else if (r < 6 || (n > 16 && r < 18)) begin
                for (int i = 0; i < n; i++)
                    send_item(OP_LOAD, VIDX_W'(i), pick_coord(style), pick_coord(style));
                sent += (n == 0) ? 1 : n;
            end else begin
                if (n > 0 && $urandom_range(0, 1) == 0) begin
                    k = $urandom_range(0, n - 1);
                    spread = (tolv > 1024) ? 1024 : tolv + 1;
                    px = sb.vx[k] + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
                    py = sb.vy[k] + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
                end else begin
                    px = pick_coord($urandom_range(0, 3));
                    py = pick_coord($urandom_range(0, 3));
                end
                send_item(OP_QUERY, VIDX_W'($urandom()), px, py);
                sent++;
            end
        end
    endtask

    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every slot gets a value before any query can read it
        for (int i = 0; i < MAX_VERTICES; i++)
            send_item(OP_LOAD, VIDX_W'(i), pick_coord(1), pick_coord(1));

        // directed: square at reset count, extremes, degenerate edges
        send_item(OP_LOAD, 6'd0, 32'h0, 32'h0);
        send_item(OP_LOAD, 6'd1, 32'h000A_0000, 32'h0);
        send_item(OP_LOAD, 6'd2, 32'h000A_0000, 32'h000A_0000);
        send_item(OP_LOAD, 6'd3, 32'h0, 32'h000A_0000);
        send_item(OP_QUERY, 6'd0, 32'h0003_0000, 32'h0004_0000);
        send_item(OP_QUERY, 6'd63, 32'h0, 32'h0);
        send_item(OP_QUERY, 6'd0, CMAX, CMIN);
        send_item(OP_QUERY, 6'd0, CMIN, CMAX);
        send_item(OP_LOAD, 6'd1, 32'h0, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h0005_0000, 32'h0001_0000);
        send_item(OP_LOAD, 6'd63, CMAX, CMIN);
        // steep short edge at the corner: distance saturates
        send_item(OP_LOAD, 6'd0, CMIN, CMIN + 1);
        send_item(OP_LOAD, 6'd1, CMIN + 1, CMIN);
        drain();
        write_reg(CFG_VCOUNT, 31'd2);
        end_writes();
        send_item(OP_QUERY, 6'd0, CMAX, CMAX);
        drain();
        write_reg(CFG_VCOUNT, 31'd1);
        end_writes();
        send_item(OP_QUERY, 6'd0, 32'h1, 32'h1);
        drain();
        write_reg(CFG_VCOUNT, 31'd0);
        write_reg(CFG_TOL, 31'h7FFF_FFFF);
        end_writes();
        send_item(OP_QUERY, 6'd0, 32'h1, 32'h1);
        drain();
        write_reg(CFG_VCOUNT, 31'd127);
        end_writes();
        send_item(OP_QUERY, 6'd0, CMAX, CMAX);
        send_item(OP_QUERY, 6'd0, 32'h0, 32'h0);

        // long hold-off on the result side while requests keep coming
        drain();
        hold_req <= 1'b1;
        run_phase(4, 31'h7FFF_FFFF, 200, 0);
        run_phase(3, 31'd0, 200, 3);
        run_phase(8, 31'($urandom_range(0, 1 << 20)), 100, 1);
        drain();
        run_phase(8, 31'($urandom_range(0, 1 << 20)), 100, 0);
        run_phase(5, 31'($urandom_range(0, 4096)), 200, 2);
        run_phase(64, 31'($urandom()), 150, 0);
        run_phase(100, 31'd0, 130, 1);
        run_phase(2, 31'($urandom_range(0, 1 << 16)), 150, 3);
        run_phase(6, 31'($urandom_range(0, 8192)), 100, 0);
        no_idle = 1'b1;
        run_phase(7, 31'd65536, 200, 0);
        drain();
        repeat (100) @(posedge i_clk);

        $display("ran %0d loads and %0d queries, %0d results checked", sb.loads, sb.queries,
                 sb.checked);
        $display("queries with an edge %0d, near a vertex %0d, saturated %0d",
                 sb.hits_found, sb.hits_near, sb.hits_sat);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
